[rtl/tgr_pkg.sv]
// Package for the text glyph renderer: payload structs, queue entry type,
// 5x7 glyph ROM function and shared constants. No dependencies.

package tgr_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_FG_COLOR = 2'd2;
    localparam logic [1:0] CFG_BG_COLOR = 2'd3;

    // Special character codes
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    // Glyph geometry and cursor steps
    localparam logic [9:0] GLYPH_W   = 10'd5;
    localparam logic [9:0] GLYPH_H   = 10'd7;
    localparam logic [9:0] LINE_STEP = 10'd9;
    localparam logic [9:0] ADV_STEP  = 10'd6;
    localparam logic [8:0] SAT_MAX   = 9'd511;

    localparam logic [2:0] COL_LAST  = 3'd4;
    localparam logic [5:0] PIX_LAST  = 6'd34;

    // Work queue between front and draw engine
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       first_of_text;
    } t_in;

    typedef struct packed {
        logic [14:0] fb_address;
        logic [15:0] pixel_value;
        logic        write_enable;
        logic        last_pixel;
    } t_out;

    typedef struct packed {
        logic [7:0]  origin_x;
        logic [6:0]  origin_y;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
    } t_cfg;

    // One character to draw: 7 rows of 5 bits, top row in the MSBs
    typedef struct packed {
        logic [34:0] glyph;
        logic [8:0]  col;
        logic [8:0]  row;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Saturating add into the 9-bit cursor range
    function automatic logic [8:0] sat_add9(input logic [8:0] a, input logic [9:0] b);
        logic [9:0] s;
        s = {1'b0, a} + b;
        return s[9] ? SAT_MAX : s[8:0];
    endfunction

    // 5x7 font ROM; lowercase folds to uppercase, unknown codes draw '?'
    function automatic logic [34:0] glyph_bitmap(input logic [7:0] code);
        logic [7:0]  c;
        logic [34:0] g;
        c = code;
        if (code >= 8'h61 && code <= 8'h7A) begin
            c = code - 8'h20;
        end
        case (c)
            8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            8'h36: g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
            8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h4A: g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
            8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
            8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            8'h3E: g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10}; // >
            8'h2F: g = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10}; // /
            8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C}; // .
            8'h3A: g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00}; // :
            8'h2B: g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00}; // +
            8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // -
            8'h5F: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F}; // _
            8'h20: g = '0;                                                 // space
            default: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04}; // ?
        endcase
        return g;
    endfunction

endpackage

[rtl/tgr_front.sv]
// Front end of the text glyph renderer: accepts characters, tracks the
// cursor and stop flag, and queues drawable glyphs. Depends on tgr_pkg.

module tgr_front #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tgr_pkg::t_in   i_in_data,
    input  tgr_pkg::t_cfg  i_cfg,
    input  tgr_pkg::t_q_stat i_q_stat,
    output logic           o_push,
    output tgr_pkg::t_job  o_job
);
    import tgr_pkg::*;

    localparam logic [9:0] W10 = 10'(SCREEN_WIDTH);
    localparam logic [9:0] H10 = 10'(SCREEN_HEIGHT);

    logic [8:0] r_col, n_col;
    logic [8:0] r_row, n_row;
    logic       r_stopped, n_stopped;

    logic [8:0] col0, row0, col1, row1;
    logic       stop0, draw, accept;

    assign o_in_ready = !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;

    // Classify the character and work out the next cursor
    always_comb begin
        col0 = i_in_data.first_of_text ? {1'b0, i_cfg.origin_x} : r_col;
        row0 = i_in_data.first_of_text ? {2'b0, i_cfg.origin_y} : r_row;
        stop0 = i_in_data.first_of_text ? 1'b0 : r_stopped;
        col1 = col0;
        row1 = row0;
        draw = 1'b0;
        n_col = col0;
        n_row = row0;
        n_stopped = stop0;
        if (i_in_data.char_code == CHAR_NUL || stop0) begin
            // nothing beyond the start-of-text effect
        end else if (i_in_data.char_code == CHAR_NEWLINE) begin
            n_col = {1'b0, i_cfg.origin_x};
            n_row = sat_add9(row0, LINE_STEP);
        end else begin
            // wrap before drawing if the glyph would reach the last column or cross the right edge
            if ({1'b0, col0} + GLYPH_W >= W10) begin
                col1 = {1'b0, i_cfg.origin_x};
                row1 = sat_add9(row0, LINE_STEP);
            end
            n_row = row1;
            if ({1'b0, row1} + GLYPH_H >= H10) begin
                n_col = col1;
                n_stopped = 1'b1;
            end else begin
                n_col = sat_add9(col1, ADV_STEP);
                draw = 1'b1;
            end
        end
    end

    assign o_push      = accept && draw;
    assign o_job.glyph = glyph_bitmap(i_in_data.char_code);
    assign o_job.col   = col1;
    assign o_job.row   = row1;

    // Cursor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_stopped <= 1'b0;
        end else if (accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_stopped <= n_stopped;
        end
    end

endmodule

[rtl/tgr_queue.sv]
// Two-entry glyph queue between the front end and the draw engine.
// Depends on tgr_pkg.

module tgr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tgr_pkg::t_job    i_job,
    input  logic             i_pop,
    output logic             o_valid,
    output tgr_pkg::t_job    o_head,
    output tgr_pkg::t_q_stat o_stat
);
    import tgr_pkg::*;

    localparam logic [QPTR_W:0] CNT_FULL = (QPTR_W + 1)'(QDEPTH);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_valid      = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign o_stat.empty = (r_cnt == '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/tgr_draw.sv]
// Draw engine: walks the 35 pixels of the queued glyph, one per cycle while
// the receiver is ready, into an output register. Depends on tgr_pkg.

module tgr_draw #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  tgr_pkg::t_job i_job,
    input  tgr_pkg::t_cfg i_cfg,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tgr_pkg::t_out o_out_data
);
    import tgr_pkg::*;

    localparam logic [9:0]  W10 = 10'(SCREEN_WIDTH);
    localparam logic [9:0]  H10 = 10'(SCREEN_HEIGHT);
    localparam logic [19:0] W20 = 20'(SCREEN_WIDTH);

    logic       r_valid;
    t_out       r_out, n_out;
    logic [5:0] r_k;
    logic [2:0] r_c, r_r;

    logic [9:0]  x, y;
    logic [19:0] addr;
    logic        on, set, produce, last;
    logic [15:0] color;

    // Pixel position, address and color
    always_comb begin
        x     = {1'b0, i_job.col} + {7'b0, r_c};
        y     = {1'b0, i_job.row} + {7'b0, r_r};
        on    = (x < W10) && (y < H10);
        addr  = {10'b0, y} * W20 + {10'b0, x};
        set   = i_job.glyph[PIX_LAST - r_k];
        color = set ? i_cfg.fg_color : i_cfg.bg_color;
        last  = (r_k == PIX_LAST);
        n_out.fb_address   = on ? addr[14:0] : '0;
        n_out.pixel_value  = {color[7:0], color[15:8]};
        n_out.write_enable = on;
        n_out.last_pixel   = last;
    end

    assign produce     = i_job_valid && (!r_valid || i_out_ready);
    assign o_pop       = produce && last;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    // Pixel counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
            r_c     <= '0;
            r_r     <= '0;
        end else if (produce) begin
            r_valid <= 1'b1;
            r_out   <= n_out;
            if (last) begin
                r_k <= '0;
                r_c <= '0;
                r_r <= '0;
            end else begin
                r_k <= r_k + 1'b1;
                if (r_c == COL_LAST) begin
                    r_c <= '0;
                    r_r <= r_r + 1'b1;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

[rtl/text_glyph_renderer_unit.sv]
// Top level of the 5x7 text glyph renderer: configuration registers, front
// end, glyph queue and draw engine. Depends on tgr_pkg and its submodules.
//
// Usage: characters enter on i_in_valid/o_in_ready with i_in_data; pixel
// writes leave on o_out_valid/i_out_ready with o_out_data. A transaction
// completes when valid and ready are both high at a rising edge.
// Configuration (origin, colors) is written through i_cfg_we/i_cfg_idx/
// i_cfg_data while no character is in flight.
// Once a printable character is accepted, its glyph is registered in the queue
// and its first pixel then in the draw engine's output register. Each printable
// character gives 35 pixel writes at one per cycle while the receiver is ready,
// as the draw engine walks one pixel per cycle. Newline, code zero and
// characters dropped below the bottom edge are consumed at the front end and
// give no writes. A two-entry queue lets the front take new characters
// while a glyph is being drawn.
// Reset (synchronous, active low) puts the cursor at (0,0), clears the stop
// flag and the queue, and loads the default colors. When the receiver stalls
// the current pixel holds in the output register; once the queue fills,
// o_in_ready drops.

module text_glyph_renderer_unit #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tgr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tgr_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);
    import tgr_pkg::*;

    localparam int AREA = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam logic [15:0] AREA16 = 16'(AREA);
    localparam logic        AREA_BIG = (AREA > 32767);

    t_cfg    r_cfg;
    t_job    front_job, head_job;
    t_q_stat q_stat;
    logic    q_push, q_pop, q_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.fg_color <= 16'hFFFF;
            r_cfg.bg_color <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X: r_cfg.origin_x <= i_cfg_data[7:0];
                CFG_ORIGIN_Y: r_cfg.origin_y <= i_cfg_data[6:0];
                CFG_FG_COLOR: r_cfg.fg_color <= i_cfg_data;
                CFG_BG_COLOR: r_cfg.bg_color <= i_cfg_data;
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    tgr_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    tgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    tgr_draw #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_draw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .i_cfg       (r_cfg),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A glyph leaves the queue only as its last pixel is loaded
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_out_valid && o_out_data.last_pixel))
        else $error("queue pop without last pixel");

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // Enabled writes land inside the framebuffer
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.write_enable) |->
            (AREA_BIG || ({1'b0, o_out_data.fb_address} < AREA16)))
        else $error("write address outside framebuffer");

endmodule
